[src/rmlp_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions of the method list parser: state codes, status codes,
// header letters and the per-byte result type. Depends on nothing.
package rmlp_pkg;

  localparam int STATE_W = 5;
  localparam int BYTE_W  = 8;
  localparam int ADDR_W  = 2;
  localparam int DATA_W  = 32;

  localparam logic [STATE_W-1:0] ST_READY      = 5'd0;
  localparam logic [STATE_W-1:0] ST_HDR_FIRST  = 5'd1;
  localparam logic [STATE_W-1:0] ST_HDR_LAST   = 5'd9;
  localparam logic [STATE_W-1:0] ST_HDR_ZERO   = 5'd10;
  localparam logic [STATE_W-1:0] ST_SKIP_FIRST = 5'd11;
  localparam logic [STATE_W-1:0] ST_SKIP_LAST  = 5'd15;
  localparam logic [STATE_W-1:0] ST_TYPE_END   = 5'd16;
  localparam logic [STATE_W-1:0] ST_M_START    = 5'd17;
  localparam logic [STATE_W-1:0] ST_M_SIG      = 5'd18;
  localparam logic [STATE_W-1:0] ST_M_NAME     = 5'd19;
  localparam logic [STATE_W-1:0] ST_M_TAIL     = 5'd20;

  localparam logic [1:0] STAT_MORE = 2'd0;
  localparam logic [1:0] STAT_DONE = 2'd1;
  localparam logic [1:0] STAT_ERR  = 2'd2;

  localparam logic [BYTE_W-1:0] CHR_NUL  = 8'h00;
  localparam logic [BYTE_W-1:0] CHR_SEMI = 8'h3B;

  localparam logic [BYTE_W-1:0] NAME_TERM_RESET = 8'h3A;

  localparam logic [ADDR_W-1:0] REG_NAME_TERM = 2'd0;

  typedef struct packed {
    logic [1:0]        status;
    logic              list_start;
    logic              method_start;
    logic              signature_valid;
    logic              name_valid;
    logic [BYTE_W-1:0] char_out;
    logic              method_end;
    logic              list_end;
  } result_t;

  // Expected header letter for states ST_HDR_FIRST through ST_HDR_LAST.
  function automatic logic [BYTE_W-1:0] hdr_letter(input logic [STATE_W-1:0] st);
    logic [BYTE_W-1:0] l;
    unique case (st)
      5'd1:    l = 8'h73;
      5'd2:    l = 8'h69;
      5'd3:    l = 8'h6D;
      5'd4:    l = 8'h70;
      5'd5:    l = 8'h6C;
      5'd6:    l = 8'h65;
      5'd7:    l = 8'h52;
      5'd8:    l = 8'h50;
      5'd9:    l = 8'h43;
      default: l = CHR_NUL;
    endcase
    return l;
  endfunction

endpackage

[src/rmlp_step.sv]
`timescale 1ns / 1ps
// Per-byte decode of the method list parser: next state and result word.
// Depends on rmlp_pkg.
module rmlp_step (
  input  logic [rmlp_pkg::STATE_W-1:0] state,
  input  logic [rmlp_pkg::BYTE_W-1:0]  data_byte,
  input  logic [rmlp_pkg::BYTE_W-1:0]  name_terminator,
  output logic [rmlp_pkg::STATE_W-1:0] state_next,
  output rmlp_pkg::result_t            result
);
  import rmlp_pkg::*;

  logic [STATE_W-1:0] s_eff;

  // The ready state and unreachable codes act as the first header state.
  assign s_eff = (state == ST_READY || state > ST_M_TAIL) ? ST_HDR_FIRST : state;

  always_comb begin
    state_next = state;
    result     = '0;
    result.status = STAT_MORE;
    priority if (s_eff <= ST_HDR_LAST) begin
      if (data_byte != hdr_letter(s_eff)) begin
        result.status = STAT_ERR;
      end else begin
        state_next = s_eff + 5'd1;
      end
    end else if (s_eff == ST_HDR_ZERO) begin
      if (data_byte != CHR_NUL) begin
        result.status = STAT_ERR;
      end else begin
        state_next = ST_SKIP_FIRST;
      end
    end else if (s_eff <= ST_SKIP_LAST) begin
      state_next = s_eff + 5'd1;
    end else if (s_eff == ST_TYPE_END) begin
      if (data_byte != CHR_NUL) begin
        result.status = STAT_ERR;
      end else begin
        state_next        = ST_M_START;
        result.list_start = 1'b1;
      end
    end else if (s_eff == ST_M_START) begin
      if (data_byte == CHR_NUL) begin
        state_next      = ST_READY;
        result.status   = STAT_DONE;
        result.list_end = 1'b1;
      end else if (data_byte == CHR_SEMI) begin
        state_next          = ST_M_NAME;
        result.method_start = 1'b1;
      end else begin
        state_next             = ST_M_SIG;
        result.method_start    = 1'b1;
        result.signature_valid = 1'b1;
        result.char_out        = data_byte;
      end
    end else if (s_eff == ST_M_SIG) begin
      if (data_byte == CHR_SEMI) begin
        state_next = ST_M_NAME;
      end else begin
        result.signature_valid = 1'b1;
        result.char_out        = data_byte;
      end
    end else if (s_eff == ST_M_NAME) begin
      if (data_byte == name_terminator) begin
        state_next = ST_M_TAIL;
      end else begin
        result.name_valid = 1'b1;
        result.char_out   = data_byte;
      end
    end else begin
      if (data_byte == CHR_NUL) begin
        state_next        = ST_M_START;
        result.method_end = 1'b1;
      end
    end
  end

endmodule

[src/rpc_method_list_parser.sv]
`timescale 1ns / 1ps
// The result word of an accepted byte appears on the output register in the next cycle.
// One byte per cycle unless out_ready stalls; the parse state register is the only feedback path.
// A new byte is taken while the output word waits, as long as that word leaves the same cycle.
// Reset (rst, synchronous, active high) returns the parser to the ready state, empties the
// output register and sets the name terminator back to ':' (0x3A).
module rpc_method_list_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [rmlp_pkg::BYTE_W-1:0]  data_byte,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   status,
  output logic                         list_start,
  output logic                         method_start,
  output logic                         signature_valid,
  output logic                         name_valid,
  output logic [rmlp_pkg::BYTE_W-1:0]  char_out,
  output logic                         method_end,
  output logic                         list_end,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rmlp_pkg::ADDR_W-1:0]  paddr,
  input  logic [rmlp_pkg::DATA_W-1:0]  pwdata,
  output logic [rmlp_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import rmlp_pkg::*;

  logic [STATE_W-1:0] state;
  logic [STATE_W-1:0] state_next;
  logic [BYTE_W-1:0]  name_terminator;
  result_t            result_next;
  result_t            result;
  logic               in_fire;
  logic               cfg_write;

  // The output register may be refilled in the cycle its word is taken.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // The register file holds one register; with a two-bit address every word
  // address decodes to it.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(DATA_W-BYTE_W){1'b0}}, name_terminator};

  always_ff @(posedge clk) begin
    if (rst) begin
      name_terminator <= NAME_TERM_RESET;
    end else if (cfg_write && (paddr == REG_NAME_TERM || paddr != REG_NAME_TERM)) begin
      name_terminator <= pwdata[BYTE_W-1:0];
    end
  end

  // All per-byte decisions are made from the current state and the incoming
  // byte in a single pass.
  rmlp_step u_step (
    .state           (state),
    .data_byte       (data_byte),
    .name_terminator (name_terminator),
    .state_next      (state_next),
    .result          (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_READY;
      out_valid <= 1'b0;
    end else begin
      if (in_fire) begin
        state <= state_next;
      end
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // The result word itself needs no reset; out_valid qualifies it.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      result <= result_next;
    end
  end

  assign status          = result.status;
  assign list_start      = result.list_start;
  assign method_start    = result.method_start;
  assign signature_valid = result.signature_valid;
  assign name_valid      = result.name_valid;
  assign char_out        = result.char_out;
  assign method_end      = result.method_end;
  assign list_end        = result.list_end;

  // A byte that reports an error must leave the parse state where it was.
  a_err_holds_state: assert property (@(posedge clk) disable iff (rst)
    in_fire && result_next.status == STAT_ERR |=> $stable(state))
    else $error("parse state moved on an error byte");

  // The end of the list always returns the parser to the ready state.
  a_list_end_ready: assert property (@(posedge clk) disable iff (rst)
    in_fire && result_next.list_end |=> state == ST_READY)
    else $error("list end did not return to ready");

  // A delivered list end carries the finished status.
  a_list_end_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && list_end |-> status == STAT_DONE)
    else $error("list end without finished status");

  // The character field is zero unless it carries a signature or name byte.
  a_char_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !signature_valid && !name_valid |-> char_out == CHR_NUL)
    else $error("char_out set without a signature or name flag");

  // Never both a signature and a name byte in one word.
  a_sig_name_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(signature_valid && name_valid))
    else $error("signature and name flags both set");

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the method list parser: byte driver, result monitor,
// parse-state predictor and register writes. Depends on rmlp_pkg and the parser RTL.
module tb_top;
  import rmlp_pkg::*;

  // Watchdog limit in cycles with no accepted word on either channel. The longest
  // legal quiet stretch is the receiver hold-off below plus a register write.
  localparam int QUIET_LIMIT = 1000;
  // After this many results the receiver holds off for a long stretch.
  localparam int PRESS_AT  = 200;
  localparam int PRESS_LEN = 80;
  // Random bytes generated per phase, six phases.
  localparam int PHASE_BYTES = 320;
  // Fixed header letters, first letter in the top byte.
  localparam logic [71:0] HDR_WORD = 72'h73_69_6D_70_6C_65_52_50_43;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [BYTE_W-1:0]   data_byte = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [1:0]          status;
  logic                list_start;
  logic                method_start;
  logic                signature_valid;
  logic                name_valid;
  logic [BYTE_W-1:0]   char_out;
  logic                method_end;
  logic                list_end;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Bytes waiting to be offered, and the per-byte results still owed by the block.
  logic [BYTE_W-1:0]   byte_q[$];
  result_t             expected_q[$];

  // Predictor copy of the parser state and the name terminator register.
  logic [STATE_W-1:0]  parse_st = ST_READY;
  logic [BYTE_W-1:0]   name_term = NAME_TERM_RESET;

  logic                idle_en = 1'b1;
  int                  fail_count = 0;
  int                  results_seen = 0;
  int                  gap_left = 0;
  int                  stall_left = 0;
  int                  hold_left = 0;
  int                  quiet_cycles = 0;

  rpc_method_list_parser u_top (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .data_byte       (data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .status          (status),
    .list_start      (list_start),
    .method_start    (method_start),
    .signature_valid (signature_valid),
    .name_valid      (name_valid),
    .char_out        (char_out),
    .method_end      (method_end),
    .list_end        (list_end),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // One line per mismatch; printing stops after the first fifty but counting goes on.
  task automatic report_mismatch(input string msg);
    if (fail_count < 50) $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic check_field(input string fname, input logic [7:0] got,
                             input logic [7:0] want, input int idx);
    if (got !== want)
      report_mismatch($sformatf("result %0d field %s: got 0x%02h, expected 0x%02h",
                                idx, fname, got, want));
  endtask

  // Works out the result word for one accepted byte and advances the predicted
  // parse state. A byte that breaks the header leaves the state where it was,
  // so the same byte is expected again.
  task automatic predict_byte(input logic [BYTE_W-1:0] b, output result_t r);
    logic [STATE_W-1:0] s;
    int                 k;
    s = parse_st;
    r = '0;
    r.status = STAT_MORE;
    // The ready state and any unused code act as the state expecting the first letter.
    if (s == ST_READY || s > ST_M_TAIL) s = ST_HDR_FIRST;
    if (s <= ST_HDR_LAST) begin
      k = s - ST_HDR_FIRST;
      if (b != HDR_WORD[8*(8-k) +: 8]) r.status = STAT_ERR;
      else parse_st = s + 1'b1;
    end else if (s == ST_HDR_ZERO) begin
      if (b != CHR_NUL) r.status = STAT_ERR;
      else parse_st = ST_SKIP_FIRST;
    end else if (s <= ST_SKIP_LAST) begin
      parse_st = s + 1'b1;
    end else if (s == ST_TYPE_END) begin
      if (b != CHR_NUL) begin
        r.status = STAT_ERR;
      end else begin
        parse_st = ST_M_START;
        r.list_start = 1'b1;
      end
    end else if (s == ST_M_START) begin
      if (b == CHR_NUL) begin
        parse_st = ST_READY;
        r.status = STAT_DONE;
        r.list_end = 1'b1;
      end else if (b == CHR_SEMI) begin
        // Empty signature: the entry starts and goes straight to the name.
        parse_st = ST_M_NAME;
        r.method_start = 1'b1;
      end else begin
        parse_st = ST_M_SIG;
        r.method_start = 1'b1;
        r.signature_valid = 1'b1;
        r.char_out = b;
      end
    end else if (s == ST_M_SIG) begin
      if (b == CHR_SEMI) begin
        parse_st = ST_M_NAME;
      end else begin
        r.signature_valid = 1'b1;
        r.char_out = b;
      end
    end else if (s == ST_M_NAME) begin
      if (b == name_term) begin
        parse_st = ST_M_TAIL;
      end else begin
        r.name_valid = 1'b1;
        r.char_out = b;
      end
    end else if (b == CHR_NUL) begin
      // Tail bytes are skipped silently until the zero byte closes the entry.
      parse_st = ST_M_START;
      r.method_end = 1'b1;
    end
  endtask

  function automatic logic [BYTE_W-1:0] rand_byte_except(input logic [BYTE_W-1:0] avoid);
    logic [BYTE_W-1:0] v;
    v = BYTE_W'($urandom_range(0, 255));
    while (v == avoid) v = BYTE_W'($urandom_range(0, 255));
    return v;
  endfunction

  // Appends one method list to the byte queue: header, skipped bytes, a few
  // entries with random content and the closing zero. Now and then the list is
  // cut short, stray bytes are slipped in, or a burst of noise follows.
  task automatic gen_list();
    logic [BYTE_W-1:0] lst[$];
    int                n_meth;
    int                cut;
    for (int k = 0; k < 9; k++) lst.push_back(HDR_WORD[8*(8-k) +: 8]);
    lst.push_back(CHR_NUL);
    for (int k = 0; k < 5; k++) lst.push_back(BYTE_W'($urandom_range(0, 255)));
    lst.push_back(CHR_NUL);
    n_meth = $urandom_range(0, 4);
    for (int m = 0; m < n_meth; m++) begin
      repeat ($urandom_range(0, 4)) lst.push_back(rand_byte_except(CHR_SEMI));
      lst.push_back(CHR_SEMI);
      repeat ($urandom_range(0, 5)) lst.push_back(rand_byte_except(name_term));
      lst.push_back(name_term);
      repeat ($urandom_range(0, 3)) lst.push_back(rand_byte_except(CHR_NUL));
      lst.push_back(CHR_NUL);
    end
    lst.push_back(CHR_NUL);
    if ($urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, lst.size() - 1);
      while (lst.size() > cut) void'(lst.pop_back());
    end
    foreach (lst[k]) begin
      if ($urandom_range(0, 49) == 0) byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
      byte_q.push_back(lst[k]);
    end
    if ($urandom_range(0, 15) == 0)
      repeat ($urandom_range(1, 8)) byte_q.push_back(BYTE_W'($urandom_range(0, 255)));
  endtask

  // Waits until every queued byte is accepted and every result has arrived, then
  // lets the pipeline settle before returning.
  task automatic drain();
    while (byte_q.size() != 0 || in_valid || expected_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Register write: setup cycle, then the access cycle in which it takes effect.
  task automatic write_name_term(input logic [BYTE_W-1:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_NAME_TERM;
    pwdata  <= {{(DATA_W-BYTE_W){1'b0}}, v};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    name_term = v;
  endtask

  // Byte driver. The word on offer is held until it is taken; between words the
  // sender now and then idles for a random stretch.
  always @(posedge clk) begin : drv_proc
    logic              nxt_valid;
    logic [BYTE_W-1:0] nxt_byte;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nxt_valid = in_valid;
      nxt_byte  = data_byte;
      if (in_valid && in_ready) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (byte_q.size() != 0) begin
          if (idle_en && $urandom_range(0, 9) == 0) begin
            gap_left = $urandom_range(0, 6);
          end else begin
            nxt_valid = 1'b1;
            nxt_byte  = byte_q.pop_front();
          end
        end
      end
      in_valid  <= nxt_valid;
      data_byte <= nxt_byte;
    end
  end

  // Result monitor. The outgoing word is checked before the byte taken at the
  // same edge is predicted, so a result that comes too early cannot match it.
  // The receiver also stalls in bursts, and once holds off long enough for the
  // block to back up and drop in_ready.
  always @(posedge clk) begin : mon_proc
    result_t got;
    result_t want;
    logic    nxt_ready;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {status, list_start, method_start, signature_valid, name_valid,
               char_out, method_end, list_end};
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_q.pop_front();
          check_field("status", got.status, want.status, results_seen);
          check_field("list_start", got.list_start, want.list_start, results_seen);
          check_field("method_start", got.method_start, want.method_start, results_seen);
          check_field("signature_valid", got.signature_valid, want.signature_valid,
                      results_seen);
          check_field("name_valid", got.name_valid, want.name_valid, results_seen);
          check_field("char_out", got.char_out, want.char_out, results_seen);
          check_field("method_end", got.method_end, want.method_end, results_seen);
          check_field("list_end", got.list_end, want.list_end, results_seen);
        end
        results_seen++;
        if (results_seen == PRESS_AT) hold_left = PRESS_LEN;
      end
      if (in_valid && in_ready) begin
        predict_byte(data_byte, want);
        expected_q.push_back(want);
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_ready = 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 6);
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
      out_ready <= nxt_ready;
    end
  end

  // Watchdog: a long stretch with no word accepted on either side means the
  // block has hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stim_proc
    logic [BYTE_W-1:0] term;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset terminator ':'. It opens with a wrong byte
    // in the ready state and a wrong letter inside the header, skips the
    // extreme values 0x00 and 0xFF, rejects a nonzero byte after the type,
    // then runs an entry with an empty signature and tail bytes, an entry whose
    // signature is 0xFF with an empty name, and the zero that ends the list.
    byte_q.push_back(8'hFF);
    byte_q.push_back(HDR_WORD[71:64]);
    byte_q.push_back(8'h58);
    for (int k = 1; k < 9; k++) byte_q.push_back(HDR_WORD[8*(8-k) +: 8]);
    byte_q.push_back(CHR_NUL);
    byte_q.push_back(8'h00);
    byte_q.push_back(8'hFF);
    byte_q.push_back(8'h01);
    byte_q.push_back(8'h80);
    byte_q.push_back(8'h7F);
    byte_q.push_back(8'h7F);
    byte_q.push_back(CHR_NUL);
    byte_q.push_back(CHR_SEMI);
    byte_q.push_back(8'h61);
    byte_q.push_back(NAME_TERM_RESET);
    byte_q.push_back(8'h55);
    byte_q.push_back(CHR_NUL);
    byte_q.push_back(8'hFF);
    byte_q.push_back(CHR_SEMI);
    byte_q.push_back(NAME_TERM_RESET);
    byte_q.push_back(CHR_NUL);
    byte_q.push_back(CHR_NUL);
    drain();

    // Random phases, each with its own terminator: both extremes, the
    // separator itself, a random value, 0x41 and the reset value. The two
    // phases without idling run at full rate; the last one closes the run.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       term = 8'h00;
        1:       term = 8'hFF;
        2:       term = CHR_SEMI;
        3:       term = BYTE_W'($urandom_range(1, 254));
        4:       term = 8'h41;
        default: term = NAME_TERM_RESET;
      endcase
      write_name_term(term);
      idle_en <= (ph != 2) && (ph != 5);
      while (byte_q.size() < PHASE_BYTES) gen_list();
      drain();
    end

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
